// File: design/pba_pkg.sv
// Shared types, constants and codes for the paragraph block allocator.
package pba_pkg;
    localparam int DEF_MAX_SEGMENTS = 64;
    localparam int PARA_W = 16;
    localparam logic [15:0] POOL_RESET = 16'd40960;

    localparam logic [1:0] CMD_ALLOC_FIRST = 2'd0;
    localparam logic [1:0] CMD_ALLOC_AT    = 2'd1;
    localparam logic [1:0] CMD_RESIZE      = 2'd2;
    localparam logic [1:0] CMD_FREE        = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_TOO_SMALL = 3'd2;
    localparam logic [2:0] ST_NOT_FREE  = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    typedef struct packed {
        logic [PARA_W-1:0] start;
        logic [PARA_W-1:0] len;
        logic              free;
        logic              used;
    } seg_t;

    // Per-cycle row operation broadcast to every cell.
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_INIT,
        OP_SHR,
        OP_SHL,
        OP_SCAN
    } op_e;

    typedef struct packed {
        op_e               op;
        logic [PARA_W-1:0] pool;
        logic [15:0]       pos;
    } row_ctl_t;
endpackage

// File: design/pba_cell.sv
// One table entry: holds a segment and moves it to a neighbor on shifts or scans.
module pba_cell
    import pba_pkg::*;
#(
    parameter int IDX_W = 6,
    parameter int IDX   = 0
) (
    input  logic     aclk,
    input  row_ctl_t ctl,
    input  seg_t     from_left,
    input  seg_t     from_right,
    input  seg_t     wr_seg,
    input  logic     wr_en,
    output seg_t     seg
);
    seg_t seg_reg, seg_next;
    logic [IDX_W-1:0] my_idx;
    assign my_idx = IDX_W'(IDX);
    assign seg = seg_reg;

    always_comb begin
        seg_next = seg_reg;
        case (ctl.op)
            OP_INIT: begin
                seg_next = '0;
                if (IDX == 0) begin
                    seg_next.len  = ctl.pool;
                    seg_next.free = 1'b1;
                    seg_next.used = 1'b1;
                end
            end
            // open a hole at pos: cells above pos take their left neighbor
            OP_SHR: if (my_idx > ctl.pos[IDX_W-1:0]) seg_next = from_left;
            // close pos: cells from pos up take their right neighbor
            OP_SHL: if (my_idx >= ctl.pos[IDX_W-1:0]) seg_next = from_right;
            // rotate the ring one step toward cell zero
            OP_SCAN: seg_next = from_right;
            default: ;
        endcase
        if (wr_en) seg_next = wr_seg;
    end

    always_ff @(posedge aclk) begin
        seg_reg <= seg_next;
    end
endmodule

// File: design/pba_ctrl.sv
// Command sequencer: scans the cell row through its head and applies edits.
module pba_ctrl
    import pba_pkg::*;
#(
    parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
    parameter int IDX_W = $clog2(MAX_SEGMENTS),
    parameter int CNT_W = $clog2(MAX_SEGMENTS + 1)
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr,
    input  logic [15:0] cfg_pool,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  cmd_in,
    input  logic [15:0] p_in,
    input  logic [15:0] size_in,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [2:0]  st_out,
    output logic [15:0] val_out,
    input  seg_t        head,
    output row_ctl_t    ctl,
    output logic [IDX_W-1:0] wr_idx,
    output logic        wr_en,
    output seg_t        wr_seg
);
    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_SCAN, S_DECIDE, S_EDIT, S_DONE
    } state_e;

    state_e state_reg;
    logic [15:0] pool_reg;
    logic [1:0]  cmd_reg;
    logic [15:0] p_reg, size_reg;
    logic [CNT_W-1:0] cnt_reg, k_reg;
    logic        hit_reg;
    logic [IDX_W-1:0] hi_reg;
    seg_t        cur_reg, nxt_reg, prv_reg;
    logic        have_prv_reg, have_nxt_reg;
    logic [15:0] best_reg;
    logic [2:0]  st_reg;
    logic [15:0] val_reg;
    logic        out_v_reg;
    // edit script: up to two row operations plus writes
    logic [2:0]  step_reg;

    assign s_tready = (state_reg == S_IDLE) && !out_v_reg;
    assign m_tvalid = out_v_reg;
    assign st_out = st_reg;
    assign val_out = val_reg;

    logic [16:0] head_end, req_end;
    logic match;
    assign head_end = {1'b0, head.start} + {1'b0, head.len};
    assign req_end  = {1'b0, p_reg} + {1'b0, size_reg};
    always_comb begin
        case (cmd_reg)
            CMD_ALLOC_FIRST: match = head.free && head.len >= size_reg;
            CMD_ALLOC_AT: match = head.start <= p_reg && {1'b0, p_reg} < head_end;
            default: match = !head.free && head.start == p_reg;
        endcase
    end

    // The scan rotates the whole ring once (MAX_SEGMENTS steps) so the table
    // returns to its place; the hit, its neighbors and index are captured.
    // Each rotation is issued via registered ctl.op; step k sees entry k at the head.
    logic [IDX_W-1:0] k_idx;
    assign k_idx = k_reg[IDX_W-1:0];

    logic [16:0] avail;
    assign avail = {1'b0, cur_reg.len} + {1'b0, nxt_reg.len};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            pool_reg  <= POOL_RESET;
            out_v_reg <= 1'b0;
            cnt_reg   <= CNT_W'(1);
            ctl.op    <= OP_HOLD;
            wr_en     <= 1'b0;
        end else begin
            ctl.op <= OP_HOLD;
            wr_en  <= 1'b0;
            if (out_v_reg && m_tready) out_v_reg <= 1'b0;
            if (cfg_wr) begin
                pool_reg  <= cfg_pool;
                state_reg <= S_INIT;
            end else begin
                case (state_reg)
                    S_INIT: begin
                        ctl.op    <= OP_INIT;
                        ctl.pool  <= pool_reg;
                        cnt_reg   <= CNT_W'(1);
                        state_reg <= S_IDLE;
                    end
                    S_IDLE: if (s_tvalid && s_tready) begin
                        cmd_reg <= cmd_in; p_reg <= p_in; size_reg <= size_in;
                        k_reg <= '0; hit_reg <= 1'b0; best_reg <= '0;
                        have_prv_reg <= 1'b0; have_nxt_reg <= 1'b0;
                        nxt_reg <= '0;
                        ctl.op <= OP_SCAN;
                        state_reg <= S_SCAN;
                    end
                    S_SCAN: begin
                        if (k_reg < cnt_reg && !hit_reg) begin
                            if (match) begin
                                hit_reg <= 1'b1; hi_reg <= k_idx; cur_reg <= head;
                                have_prv_reg <= (k_reg != '0);
                            end else begin
                                prv_reg <= head;
                                if (head.free && head.len > best_reg) best_reg <= head.len;
                            end
                        end else if (hit_reg && k_reg == CNT_W'(hi_reg) + CNT_W'(1)
                                     && k_reg < cnt_reg) begin
                            nxt_reg <= head; have_nxt_reg <= 1'b1;
                        end
                        if (k_reg == CNT_W'(MAX_SEGMENTS - 1)) state_reg <= S_DECIDE;
                        else ctl.op <= OP_SCAN;
                        k_reg <= k_reg + CNT_W'(1);
                    end
                    S_DECIDE: begin
                        // default: finish with no edit
                        step_reg <= '0;
                        st_reg <= ST_OK; val_reg <= '0;
                        state_reg <= S_DONE;
                        case (cmd_reg)
                            CMD_ALLOC_FIRST, CMD_ALLOC_AT: begin
                                if (!hit_reg) begin
                                    st_reg  <= (cmd_reg == CMD_ALLOC_FIRST)
                                               ? ST_TOO_SMALL : ST_NOT_FOUND;
                                    val_reg <= (cmd_reg == CMD_ALLOC_FIRST) ? best_reg : '0;
                                end else if (!cur_reg.free) begin
                                    st_reg <= ST_NOT_FREE;
                                end else if (cmd_reg == CMD_ALLOC_AT && req_end >
                                             {1'b0, cur_reg.start} + {1'b0, cur_reg.len}) begin
                                    st_reg  <= ST_TOO_SMALL;
                                    val_reg <= 16'(({1'b0, cur_reg.start}
                                               + {1'b0, cur_reg.len}) - {1'b0, p_reg});
                                end else begin
                                    val_reg <= (cmd_reg == CMD_ALLOC_FIRST)
                                               ? cur_reg.start : p_reg;
                                    if (cmd_reg == CMD_ALLOC_FIRST) p_reg <= cur_reg.start;
                                    if (size_reg != '0) begin
                                        step_reg <= 3'd1; state_reg <= S_EDIT;
                                    end
                                end
                            end
                            default: begin
                                if (!hit_reg) begin
                                    st_reg <= ST_NOT_FOUND;
                                end else if (cmd_reg == CMD_FREE || size_reg == '0) begin
                                    step_reg <= 3'd4; state_reg <= S_EDIT;
                                end else if (size_reg == cur_reg.len) begin
                                    val_reg <= size_reg;
                                end else if (size_reg < cur_reg.len) begin
                                    if (have_nxt_reg && nxt_reg.free) begin
                                        val_reg <= size_reg; step_reg <= 3'd6;
                                        state_reg <= S_EDIT;
                                    end else if (cnt_reg >= CNT_W'(MAX_SEGMENTS)) begin
                                        st_reg <= ST_FULL;
                                    end else begin
                                        val_reg <= size_reg; step_reg <= 3'd7;
                                        state_reg <= S_EDIT;
                                    end
                                end else if (!(have_nxt_reg && nxt_reg.free)) begin
                                    st_reg <= ST_TOO_SMALL; val_reg <= cur_reg.len;
                                end else if ({1'b0, size_reg} > avail) begin
                                    st_reg <= ST_TOO_SMALL;
                                    val_reg <= avail[16] ? 16'hFFFF : avail[15:0];
                                end else begin
                                    val_reg <= size_reg; step_reg <= 3'd5;
                                    state_reg <= S_EDIT;
                                end
                            end
                        endcase
                    end
                    S_EDIT: begin
                        state_reg <= S_DONE;
                        case (step_reg)
                            3'd1: begin
                                // carve: check room, then split off head and tail;
                                // a full table keeps the start as the value
                                if (cnt_reg + CNT_W'(p_reg != cur_reg.start)
                                    + CNT_W'(req_end < {1'b0, cur_reg.start}
                                             + {1'b0, cur_reg.len})
                                    > CNT_W'(MAX_SEGMENTS)) begin
                                    st_reg <= ST_FULL;
                                end else if (p_reg != cur_reg.start) begin
                                    ctl.op <= OP_SHR; ctl.pos <= 16'(hi_reg);
                                    cnt_reg <= cnt_reg + CNT_W'(1);
                                    wr_en <= 1'b1; wr_idx <= hi_reg;
                                    wr_seg <= '{cur_reg.start, p_reg - cur_reg.start,
                                                1'b1, 1'b1};
                                    hi_reg <= hi_reg + IDX_W'(1);
                                    cur_reg.len <= cur_reg.len - (p_reg - cur_reg.start);
                                    cur_reg.start <= p_reg;
                                    state_reg <= S_EDIT;
                                end else begin
                                    wr_en <= 1'b1; wr_idx <= hi_reg;
                                    wr_seg <= '{p_reg, size_reg, 1'b0, 1'b1};
                                    if (req_end < {1'b0, cur_reg.start} + {1'b0, cur_reg.len})
                                        begin
                                        step_reg <= 3'd2; state_reg <= S_EDIT;
                                    end
                                end
                            end
                            3'd2: begin
                                ctl.op <= OP_SHR; ctl.pos <= 16'(hi_reg);
                                cnt_reg <= cnt_reg + CNT_W'(1);
                                wr_en <= 1'b1; wr_idx <= hi_reg + IDX_W'(1);
                                wr_seg <= '{16'(req_end), cur_reg.len - size_reg,
                                            1'b1, 1'b1};
                            end
                            3'd4: begin
                                // free: absorb a free next, then merge into a free previous
                                if (have_nxt_reg && nxt_reg.free) begin
                                    ctl.op <= OP_SHL; ctl.pos <= 16'(hi_reg) + 16'd1;
                                    cnt_reg <= cnt_reg - CNT_W'(1);
                                    cur_reg.len <= cur_reg.len + nxt_reg.len;
                                    have_nxt_reg <= 1'b0;
                                    state_reg <= S_EDIT;
                                end else if (have_prv_reg && prv_reg.free) begin
                                    ctl.op <= OP_SHL; ctl.pos <= 16'(hi_reg);
                                    cnt_reg <= cnt_reg - CNT_W'(1);
                                    step_reg <= 3'd3; state_reg <= S_EDIT;
                                end else begin
                                    wr_en <= 1'b1; wr_idx <= hi_reg;
                                    wr_seg <= '{cur_reg.start, cur_reg.len, 1'b1, 1'b1};
                                end
                            end
                            3'd3: begin
                                wr_en <= 1'b1; wr_idx <= hi_reg - IDX_W'(1);
                                wr_seg <= '{prv_reg.start, prv_reg.len + cur_reg.len,
                                            1'b1, 1'b1};
                            end
                            3'd5: begin
                                wr_en <= 1'b1; wr_idx <= hi_reg;
                                wr_seg <= '{cur_reg.start, size_reg, 1'b0, 1'b1};
                                if ({1'b0, size_reg} == avail) begin
                                    step_reg <= 3'd0; state_reg <= S_EDIT;
                                end else begin
                                    nxt_reg.len <= nxt_reg.len - (size_reg - cur_reg.len);
                                    nxt_reg.start <= nxt_reg.start + (size_reg - cur_reg.len);
                                    step_reg <= 3'd6; state_reg <= S_EDIT;
                                    cur_reg.len <= size_reg;
                                end
                            end
                            3'd0: begin
                                ctl.op <= OP_SHL; ctl.pos <= 16'(hi_reg) + 16'd1;
                                cnt_reg <= cnt_reg - CNT_W'(1);
                            end
                            3'd6: begin
                                // shrink into a free next, or finish a partial grow
                                wr_en <= 1'b1; wr_idx <= hi_reg + IDX_W'(1);
                                if (size_reg < cur_reg.len) begin
                                    wr_seg <= '{nxt_reg.start - (cur_reg.len - size_reg),
                                                nxt_reg.len + (cur_reg.len - size_reg),
                                                1'b1, 1'b1};
                                    cur_reg.len <= size_reg;
                                    step_reg <= 3'd5; state_reg <= S_EDIT;
                                    nxt_reg.len <= nxt_reg.len + (cur_reg.len - size_reg);
                                    nxt_reg.start <= nxt_reg.start - (cur_reg.len - size_reg);
                                end else begin
                                    wr_seg <= nxt_reg;
                                end
                            end
                            3'd7: begin
                                ctl.op <= OP_SHR; ctl.pos <= 16'(hi_reg);
                                cnt_reg <= cnt_reg + CNT_W'(1);
                                wr_en <= 1'b1; wr_idx <= hi_reg + IDX_W'(1);
                                wr_seg <= '{p_reg + size_reg, cur_reg.len - size_reg,
                                            1'b1, 1'b1};
                                cur_reg.len <= size_reg; nxt_reg <= '0;
                                step_reg <= 3'd6; state_reg <= S_EDIT;
                                have_nxt_reg <= 1'b0;
                            end
                            default: ;
                        endcase
                        // a shrink that opened a slot writes the used entry last
                        if (step_reg == 3'd6 && size_reg >= cur_reg.len && !have_nxt_reg)
                            begin
                            wr_seg <= '{cur_reg.start, size_reg, 1'b0, 1'b1};
                            wr_idx <= hi_reg;
                        end
                    end
                    S_DONE: begin
                        out_v_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    default: state_reg <= S_INIT;
                endcase
            end
        end
    end
endmodule

// File: design/paragraph_block_allocator.sv
// Top level of the first-fit paragraph block allocator.
// The segment table lives in a ring of MAX_SEGMENTS cells, one entry each.
// A command is one s_ beat and gives one m_ beat. Each command rotates the
// ring once past cell zero to search it, decides, then applies its edits,
// each at most one shift of the whole row plus one entry write, and posts
// the result. m_tvalid rises once the search, decision and any edits are
// done; s_tready returns the cycle after the m_ beat, so a new command
// waits out the whole previous one plus any m_tready stall. One command is
// in flight at a time. Writing pool_paragraphs (address 0) reinitializes
// the table through the S_INIT state; s_tready stays low until then.
// s_tdata: command[1:0], start_paragraph[17:2], size_paragraphs[33:18],
// zero pad to 40 bits. m_tdata: status[2:0], value[18:3], zero pad to 24 bits.
module paragraph_block_allocator
    import pba_pkg::*;
#(
    parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // command, start_paragraph, size_paragraphs
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // status, value
);
    localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

    logic [15:0] pool_shadow_reg;
    logic cfg_wr;
    assign pready = 1'b1;
    // only address 0 holds a register; other writes are ignored
    assign cfg_wr = psel && penable && pwrite && (paddr == 1'b0);
    assign prdata = (paddr == 1'b0) ? {16'd0, pool_shadow_reg} : 32'd0;
    always_ff @(posedge aclk) begin
        if (!aresetn) pool_shadow_reg <= POOL_RESET;
        else if (cfg_wr) pool_shadow_reg <= pwdata[15:0];
    end

    row_ctl_t ctl;
    logic [IDX_W-1:0] wr_idx;
    logic wr_en;
    seg_t wr_seg;
    seg_t segs [MAX_SEGMENTS];
    logic [2:0] st;
    logic [15:0] val;

    pba_ctrl #(.MAX_SEGMENTS(MAX_SEGMENTS), .IDX_W(IDX_W)) u_ctrl (
        .aclk, .aresetn, .cfg_wr, .cfg_pool(pwdata[15:0]),
        .s_tvalid, .s_tready, .cmd_in(s_tdata[1:0]), .p_in(s_tdata[17:2]),
        .size_in(s_tdata[33:18]), .m_tvalid, .m_tready, .st_out(st), .val_out(val),
        .head(segs[0]), .ctl, .wr_idx, .wr_en, .wr_seg
    );

    for (genvar g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
        pba_cell #(.IDX_W(IDX_W), .IDX(g)) u_cell (
            .aclk, .ctl,
            .from_left(segs[(g + MAX_SEGMENTS - 1) % MAX_SEGMENTS]),
            .from_right(segs[(g + 1) % MAX_SEGMENTS]),
            .wr_seg, .wr_en(wr_en && wr_idx == IDX_W'(g)), .seg(segs[g])
        );
    end

    assign m_tdata = {5'd0, val, st};
endmodule

// File: dv/paragraph_block_allocator_tb.sv
// Testbench for the paragraph block allocator: directed and random commands checked against a segment-table predictor.
module paragraph_block_allocator_tb
    import pba_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SEGMENTS = DEF_MAX_SEGMENTS;
    // Cycles to let pass before a register write.
    localparam int DRAIN_CYCLES = MAX_SEGMENTS + 20;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] value;
    } outcome_t;

    logic        aclk;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [0:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // command[1:0], start_paragraph[17:2], size_paragraphs[33:18]
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // status[2:0], value[18:3]

    paragraph_block_allocator #(.MAX_SEGMENTS(MAX_SEGMENTS)) dut (.*);

    // Free-running clock, 12 ns period.
    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // Predicted copy of the segment table and pool register.
    logic [15:0] pool_size;
    logic [15:0] seg_begin [MAX_SEGMENTS];
    logic [15:0] seg_len [MAX_SEGMENTS];
    bit          seg_open [MAX_SEGMENTS];
    int          seg_total;

    outcome_t    pending_outcomes[$];
    bit          failed;
    bit          steady;   // when set, both sides run without gaps

    // ---------------------------------------------------------------
    // Segment table predictor
    // ---------------------------------------------------------------
    function automatic void reset_table();
        for (int i = 0; i < MAX_SEGMENTS; i++) begin
            seg_begin[i] = '0;
            seg_len[i]   = '0;
            seg_open[i]  = 1'b0;
        end
        seg_len[0]  = pool_size;
        seg_open[0] = 1'b1;
        seg_total   = 1;
    endfunction

    // Shift entries up to make a hole at pos.
    function automatic void insert_hole(int pos);
        for (int i = seg_total; i > pos; i--) begin
            seg_begin[i] = seg_begin[i-1];
            seg_len[i]   = seg_len[i-1];
            seg_open[i]  = seg_open[i-1];
        end
        seg_total++;
    endfunction

    // Shift entries down over pos and clear the vacated tail entry.
    function automatic void remove_entry(int pos);
        for (int i = pos; i + 1 < seg_total; i++) begin
            seg_begin[i] = seg_begin[i+1];
            seg_len[i]   = seg_len[i+1];
            seg_open[i]  = seg_open[i+1];
        end
        seg_total--;
        seg_begin[seg_total] = '0;
        seg_len[seg_total]   = '0;
        seg_open[seg_total]  = 1'b0;
    endfunction

    // Split [p, p+size) out of free entry idx; returns the status.
    function automatic logic [2:0] split_free(int idx, int unsigned p, int unsigned size);
        int unsigned s;
        int unsigned stop;
        int          pre;
        int          post;
        s    = seg_begin[idx];
        stop = s + seg_len[idx];
        pre  = (p != s) ? 1 : 0;
        post = (stop > p + size) ? 1 : 0;
        if (seg_total + pre + post > MAX_SEGMENTS) return ST_FULL;
        if (pre != 0) begin
            insert_hole(idx);
            seg_begin[idx] = s[15:0];
            seg_len[idx]   = 16'(p - s);
            seg_open[idx]  = 1'b1;
            idx++;
        end
        seg_begin[idx] = p[15:0];
        seg_len[idx]   = size[15:0];
        seg_open[idx]  = 1'b0;
        if (post != 0) begin
            insert_hole(idx + 1);
            seg_begin[idx+1] = 16'(p + size);
            seg_len[idx+1]   = 16'(stop - p - size);
            seg_open[idx+1]  = 1'b1;
        end
        return ST_OK;
    endfunction

    function automatic int find_taken(int unsigned p);
        for (int i = 0; i < seg_total; i++)
            if (seg_begin[i] == p[15:0] && !seg_open[i]) return i;
        return -1;
    endfunction

    // Mark entry i free and merge it with free neighbors.
    function automatic void give_back(int i);
        seg_open[i] = 1'b1;
        if (i + 1 < seg_total && seg_open[i+1]) begin
            seg_len[i] = seg_len[i] + seg_len[i+1];
            remove_entry(i + 1);
        end
        if (i > 0 && seg_open[i-1]) begin
            seg_len[i-1] = seg_len[i-1] + seg_len[i];
            remove_entry(i);
        end
    endfunction

    function automatic outcome_t apply_command(logic [1:0] cmd, logic [15:0] start_p,
                                               logic [15:0] size_p);
        outcome_t    res;
        int unsigned p;
        int unsigned size;
        int unsigned best;
        int unsigned stop;
        int unsigned cur;
        int unsigned avail;
        int unsigned diff;
        int          idx;
        bit          next_open;
        p    = start_p;
        size = size_p;
        res.status = ST_OK;
        res.value  = '0;
        idx  = -1;
        best = 0;
        case (cmd)
            CMD_ALLOC_FIRST: begin
                for (int i = 0; i < seg_total; i++) begin
                    if (seg_open[i]) begin
                        if (seg_len[i] >= size) begin
                            idx = i;
                            break;
                        end
                        if (seg_len[i] > best) best = seg_len[i];
                    end
                end
                if (idx < 0) begin
                    res.status = ST_TOO_SMALL;
                    res.value  = best[15:0];
                end else begin
                    res.value = seg_begin[idx];
                    if (size > 0) res.status = split_free(idx, seg_begin[idx], size);
                end
            end
            CMD_ALLOC_AT: begin
                for (int i = 0; i < seg_total; i++) begin
                    if (seg_begin[i] <= p && p < seg_begin[i] + seg_len[i]) begin
                        idx = i;
                        break;
                    end
                end
                if (idx < 0) res.status = ST_NOT_FOUND;
                else if (!seg_open[idx]) res.status = ST_NOT_FREE;
                else begin
                    stop = seg_begin[idx] + seg_len[idx];
                    if (p + size > stop) begin
                        res.status = ST_TOO_SMALL;
                        res.value  = 16'(stop - p);
                    end else begin
                        res.value = start_p;
                        if (size > 0) res.status = split_free(idx, p, size);
                    end
                end
            end
            CMD_RESIZE: begin
                idx = find_taken(p);
                if (idx < 0) res.status = ST_NOT_FOUND;
                else if (size == 0) give_back(idx);
                else begin
                    cur       = seg_len[idx];
                    next_open = (idx + 1 < seg_total) && seg_open[idx+1];
                    if (size == cur) res.value = size_p;
                    else if (size < cur) begin
                        diff = cur - size;
                        if (next_open) begin
                            seg_begin[idx+1] = 16'(seg_begin[idx+1] - diff);
                            seg_len[idx+1]   = 16'(seg_len[idx+1] + diff);
                            seg_len[idx]     = size_p;
                            res.value        = size_p;
                        end else if (seg_total >= MAX_SEGMENTS) begin
                            res.status = ST_FULL;
                        end else begin
                            seg_len[idx] = size_p;
                            insert_hole(idx + 1);
                            seg_begin[idx+1] = 16'(p + size);
                            seg_len[idx+1]   = diff[15:0];
                            seg_open[idx+1]  = 1'b1;
                            res.value        = size_p;
                        end
                    end else if (!next_open) begin
                        res.status = ST_TOO_SMALL;
                        res.value  = cur[15:0];
                    end else begin
                        avail = cur + seg_len[idx+1];
                        if (size > avail) begin
                            res.status = ST_TOO_SMALL;
                            res.value  = (avail > 32'hFFFF) ? 16'hFFFF : avail[15:0];
                        end else begin
                            diff         = size - cur;
                            seg_len[idx] = size_p;
                            if (size == avail) remove_entry(idx + 1);
                            else begin
                                seg_len[idx+1]   = 16'(seg_len[idx+1] - diff);
                                seg_begin[idx+1] = 16'(seg_begin[idx+1] + diff);
                            end
                            res.value = size_p;
                        end
                    end
                end
            end
            default: begin
                idx = find_taken(p);
                if (idx < 0) res.status = ST_NOT_FOUND;
                else give_back(idx);
            end
        endcase
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Gaps: mostly none or short, now and then long.
    // ---------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 19);
        if (r < 12) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ---------------------------------------------------------------
    // Result side: random backpressure and the checker.
    // ---------------------------------------------------------------
    int ready_left;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            ready_left <= 0;
        end else if (steady) begin
            m_tready <= 1'b1;
        end else if (ready_left == 0) begin
            // Pick a new stretch: ready for a while, or stalled for a gap.
            if ($urandom_range(0, 2) != 0) begin
                m_tready   <= 1'b1;
                ready_left <= $urandom_range(1, 12);
            end else begin
                m_tready   <= 1'b0;
                ready_left <= pick_gap();
            end
        end else begin
            ready_left <= ready_left - 1;
        end
    end

    always @(posedge aclk) begin
        outcome_t got;
        outcome_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = m_tdata[2:0];
            got.value  = m_tdata[18:3];
            if (pending_outcomes.size() == 0) begin
                $display("%0t: unexpected result beat status=%0d value=%0d",
                         $time, got.status, got.value);
                failed = 1'b1;
            end else begin
                want = pending_outcomes.pop_front();
                if (got.status !== want.status) begin
                    $display("%0t: status mismatch expected=%0d actual=%0d",
                             $time, want.status, got.status);
                    failed = 1'b1;
                end
                if (got.value !== want.value) begin
                    $display("%0t: value mismatch expected=%0d actual=%0d",
                             $time, want.value, got.value);
                    failed = 1'b1;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus tasks
    // ---------------------------------------------------------------
    // Send one command beat; predict its result at the accepting edge.
    // Leaves s_tvalid high so back-to-back beats need no second assignment.
    task automatic send_command(logic [1:0] cmd, logic [15:0] start_p, logic [15:0] size_p);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, size_p, start_p, cmd};
        do @(posedge aclk); while (!s_tready);
        pending_outcomes.push_back(apply_command(cmd, start_p, size_p));
    endtask

    // Drop valid, wait for every result, then let the block settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Two-phase register write; the predicted table is reset at the access edge.
    task automatic write_pool(logic [15:0] paras);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 1'b0;
        pwdata  <= {16'b0, paras};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        pool_size  = paras;
        reset_table();
    endtask

    // Start near the live table most of the time so commands hit real segments.
    function automatic logic [15:0] pick_start();
        int r;
        int i;
        r = $urandom_range(0, 9);
        i = $urandom_range(0, seg_total - 1);
        if (r < 7) return seg_begin[i];
        if (r < 9) return 16'(seg_begin[i] + $urandom_range(0, seg_len[i]));
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] pick_size();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 16'($urandom);
        if (r == 1) return 16'd0;
        if (pool_size < 16) return 16'($urandom_range(0, 16));
        return 16'($urandom_range(1, pool_size / 8));
    endfunction

    // Extremes and the special cases short of a full table, on the reset pool of 40960.
    task automatic test_directed();
        send_command(CMD_ALLOC_FIRST, 16'd0, 16'd0);        // zero size: first free start
        send_command(CMD_ALLOC_FIRST, 16'd0, 16'd100);      // 0..99
        send_command(CMD_ALLOC_FIRST, 16'd0, 16'hFFFF);     // nothing fits
        send_command(CMD_ALLOC_AT, 16'd50, 16'd4);          // used target
        send_command(CMD_ALLOC_AT, 16'hFFFF, 16'd1);        // outside the pool
        send_command(CMD_ALLOC_AT, 16'd40950, 16'd20);      // runs past the end
        send_command(CMD_ALLOC_AT, 16'd300, 16'd0);         // zero size at a free spot
        send_command(CMD_ALLOC_AT, 16'd300, 16'd50);        // split with hole before
        send_command(CMD_RESIZE, 16'd7, 16'd5);             // unknown start
        send_command(CMD_RESIZE, 16'd100, 16'd5);           // start of a free segment
        send_command(CMD_RESIZE, 16'd0, 16'd150);           // grow, next is free: 100..299
        send_command(CMD_RESIZE, 16'd0, 16'd400);           // grow beyond free next
        send_command(CMD_RESIZE, 16'd0, 16'd200);           // grow into part of free next
        send_command(CMD_RESIZE, 16'd0, 16'd250);           // grow again, next still free
        send_command(CMD_RESIZE, 16'd0, 16'd120);           // shrink into free next
        send_command(CMD_RESIZE, 16'd0, 16'd90);            // shrink into free next
        send_command(CMD_RESIZE, 16'd0, 16'd90);            // same size
        send_command(CMD_RESIZE, 16'd300, 16'd0);           // resize to zero frees
        send_command(CMD_FREE, 16'd300, 16'd0);             // already free
        send_command(CMD_ALLOC_FIRST, 16'd0, 16'd10);       // lands in the gap
        send_command(CMD_FREE, 16'd90, 16'd0);              // merge with free next
        send_command(CMD_FREE, 16'd0, 16'hFFFF);            // merge everything back
        send_command(CMD_ALLOC_FIRST, 16'hFFFF, 16'd40960); // whole pool
        send_command(CMD_FREE, 16'd0, 16'd0);
    endtask

    // Pool extremes: empty, single paragraph and full width.
    task automatic test_pool_extremes();
        write_pool(16'd0);
        send_command(CMD_ALLOC_AT, 16'd0, 16'd0);
        send_command(CMD_ALLOC_FIRST, 16'd0, 16'd0);
        send_command(CMD_ALLOC_FIRST, 16'd0, 16'd1);
        write_pool(16'd1);
        send_command(CMD_ALLOC_AT, 16'd0, 16'd2);
        send_command(CMD_ALLOC_AT, 16'd0, 16'd1);
        send_command(CMD_ALLOC_FIRST, 16'd0, 16'd1);
        write_pool(16'hFFFF);
        send_command(CMD_ALLOC_AT, 16'hFFFE, 16'd2);
        send_command(CMD_ALLOC_AT, 16'hFFFE, 16'd1);
        send_command(CMD_ALLOC_FIRST, 16'd0, 16'hFFFE);
        send_command(CMD_RESIZE, 16'd0, 16'hFFFF);           // grow to fill, tail used
        send_command(CMD_RESIZE, 16'hFFFE, 16'd0);
        send_command(CMD_RESIZE, 16'd0, 16'hFFFF);
        send_command(CMD_FREE, 16'd0, 16'd0);
    endtask

    // Fill the table with one-paragraph segments until commands report it full.
    task automatic test_table_full();
        write_pool(16'd100);
        for (int i = 0; i < MAX_SEGMENTS + 2; i++)
            send_command(CMD_ALLOC_FIRST, 16'd0, 16'd1);
        send_command(CMD_ALLOC_AT, 16'd90, 16'd1);           // needs two entries
        send_command(CMD_RESIZE, 16'd62, 16'd0);             // free the last used one, merging with the tail
        send_command(CMD_RESIZE, 16'd0, 16'd2);              // no free next
        send_command(CMD_ALLOC_AT, 16'd62, 16'd1);           // refill that start, splitting the free tail
        send_command(CMD_ALLOC_AT, 16'd98, 16'd2);           // table stays full
    endtask

    // Random commands, mostly aimed at live segments, over a set of pool sizes.
    task automatic test_random();
        logic [15:0] pools [6];
        pools = '{16'd200, 16'd64, 16'd1000, 16'd30, 16'hFFFF, 16'd40960};
        foreach (pools[k]) begin
            write_pool(pools[k]);
            steady = (k == 2);
            for (int n = 0; n < 105; n++)
                send_command(2'($urandom_range(0, 3)), pick_start(), pick_size());
        end
        steady = 1'b0;
    endtask

    initial begin
        failed    = 1'b0;
        steady    = 1'b0;
        aresetn   = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        pool_size = POOL_RESET;
        reset_table();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_pool_extremes();
        test_table_full();
        test_random();

        drain();
        if (!failed)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog well above the slowest legal run.
    initial begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule

// File: files.f
design/pba_pkg.sv
design/pba_cell.sv
design/pba_ctrl.sv
design/paragraph_block_allocator.sv
dv/paragraph_block_allocator_tb.sv
